### rtl/arsf_pkg.sv
// Package for the anti-replay sender filter: payload structs, codes,
// slot table entry type and sequencer states. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package arsf_pkg;

  localparam int unsigned SENDER_SLOTS_DEF = 8;
  localparam int unsigned CFG_IDX_W        = 4;
  localparam int unsigned CFG_DATA_W       = 32;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TIME_MODE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW    = CFG_IDX_W'(1);

  typedef enum logic [1:0] {
    VERDICT_OK       = 2'd0,
    VERDICT_STALE    = 2'd1,
    VERDICT_BAD_HMAC = 2'd2,
    VERDICT_REPLAY   = 2'd3
  } verdict_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SKEW,
    ST_SCAN,
    ST_AGE,
    ST_SERIAL,
    ST_DONE
  } arsf_state_e;

  typedef struct packed {
    logic        addr_is_v6;
    logic [63:0] addr_high;
    logic [63:0] addr_low;
    logic [63:0] sequence_req;
    logic [31:0] now_seconds;
    logic        hmac_good;
  } arsf_in_t;

  typedef struct packed {
    logic [1:0]         verdict;
    logic signed [31:0] clock_skew;
  } arsf_out_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } arsf_cfg_t;

  // One entry of the sender table (occupancy and mark valid live in flops)
  typedef struct packed {
    logic [31:0] rank;
    logic        is_v6;
    logic [63:0] addr_high;
    logic [63:0] addr_low;
    logic [63:0] mark_seq;
  } arsf_slot_t;

endpackage

`default_nettype wire

### rtl/arsf_stream_if.sv
// Valid/ready channel interface carrying one payload per transaction.
// Payload type is a parameter; used with the structs of arsf_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface arsf_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

### rtl/anti_replay_sender_filter.sv
// Anti-replay filter for received adverts with an LRU table of senders.
// Depends on arsf_pkg and arsf_stream_if.
//
//  channel | dir | payload     | transaction
//  --------+-----+-------------+---------------------------------------
//  cfg_i   | in  | arsf_cfg_t  | register write, always ready
//  in_i    | in  | arsf_in_t   | one advert, ready only when idle
//  out_o   | out | arsf_out_t  | one verdict per advert, output register
//
// Sequence: an advert that reaches the table is scanned one slot a cycle through
// the single read port of the slot memory; after a hit or the last slot it
// passes ST_AGE, ST_SERIAL and ST_DONE before the result register is loaded.
// Stale and bad-HMAC adverts go from ST_SKEW straight to ST_DONE. Ready is high
// again from the edge that loads the result register.
// Reset clears occupancy and mark valid flops at once; no clearing pass.
// A stalled result holds in the output register; the next advert is taken
// meanwhile and waits in the last state only if the register is still full.
`timescale 1ns / 1ps
`default_nettype none

module anti_replay_sender_filter
  import arsf_pkg::*;
#(
  parameter int unsigned SENDER_SLOTS = SENDER_SLOTS_DEF
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  arsf_stream_if.sink   cfg_i,
  arsf_stream_if.sink   in_i,
  arsf_stream_if.source out_o
);

  localparam int unsigned IDX_W = (SENDER_SLOTS > 1) ? $clog2(SENDER_SLOTS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SENDER_SLOTS - 1);

  // Configuration registers
  logic        time_mode_q;
  logic [15:0] window_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_mode_q <= 1'b0;
      window_q    <= '0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.payload.index)
        REG_TIME_MODE: time_mode_q <= cfg_i.payload.data[0];
        REG_WINDOW:    window_q    <= cfg_i.payload.data[15:0];
        default: ;
      endcase
    end
  end

  // Signed seconds difference outside +/- window
  function automatic logic outside_win(input logic [31:0] diff, input logic [15:0] win);
    logic signed [32:0] d;
    logic signed [32:0] w;
    d = {diff[31], diff};
    w = {17'b0, win};
    return (d > w) || (d < -w);
  endfunction

  arsf_state_e state_q, state_d;

  arsf_in_t    adv_q;
  logic [31:0] skew_q, skew_d;
  verdict_e    verdict_q, verdict_d;
  logic [IDX_W-1:0] scan_idx_q, scan_idx_d;
  logic [IDX_W-1:0] slot_q, slot_d;
  logic [IDX_W-1:0] victim_q, victim_d;
  logic [31:0]      vrank_q, vrank_d;
  logic             found_q, found_d;
  logic             mark_live_q, mark_live_d;
  logic [31:0]      rank_clock_q, rank_clock_d;

  logic [SENDER_SLOTS-1:0] used_q;
  logic [SENDER_SLOTS-1:0] mark_valid_q;

  // Slot memory: one write port, one registered read port
  arsf_slot_t slot_mem [SENDER_SLOTS];
  arsf_slot_t rd_q;
  logic       rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic       wr_en;
  arsf_slot_t wr_data;

  always_ff @(posedge clk_i) begin
    if (wr_en) slot_mem[slot_q] <= wr_data;
    if (rd_en) rd_q <= slot_mem[rd_addr];
  end

  // Output register
  logic      out_valid_q;
  arsf_out_t out_q;
  logic      out_load;

  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q.verdict    <= verdict_q;
      out_q.clock_skew <= $signed(skew_q);
    end
  end

  // Input latch, IPv4 addresses masked on entry
  arsf_in_t adv_in;

  assign in_i.ready = (state_q == ST_IDLE);

  always_comb begin
    adv_in = in_i.payload;
    if (!in_i.payload.addr_is_v6) begin
      adv_in.addr_high       = '0;
      adv_in.addr_low[63:32] = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      adv_q <= adv_in;
    end
  end

  // Shared 64-bit subtractor
  logic [63:0] sub_a, sub_b, diff;

  always_comb begin
    case (state_q)
      ST_SKEW: begin
        sub_a = {adv_q.now_seconds, 32'd0};
        sub_b = {adv_q.sequence_req[63:32], 32'd0};
      end
      ST_AGE: begin
        sub_a = {adv_q.now_seconds, 32'd0};
        sub_b = {rd_q.mark_seq[63:32], 32'd0};
      end
      default: begin
        sub_a = adv_q.sequence_req;
        sub_b = rd_q.mark_seq;
      end
    endcase
    diff = sub_a - sub_b;
  end

  // Scan compare on the slot in the read register
  logic [31:0] cur_rank;
  logic        cur_match;
  logic        cur_less;

  assign cur_rank  = used_q[scan_idx_q] ? rd_q.rank : 32'd0;
  assign cur_match = used_q[scan_idx_q] && (rd_q.is_v6 == adv_q.addr_is_v6) &&
                     (rd_q.addr_high == adv_q.addr_high) &&
                     (rd_q.addr_low == adv_q.addr_low);
  assign cur_less  = (scan_idx_q == '0) || (cur_rank < vrank_q);

  logic [31:0] rank_next;
  logic        serial_after;
  logic        replay;

  assign rank_next    = ((rank_clock_q + 32'd1) == 32'd0) ? 32'd1 : rank_clock_q + 32'd1;
  assign serial_after = (diff != 64'd0) && !diff[63];
  assign replay       = mark_live_q && !serial_after;

  // Sequencer: next state and datapath controls
  always_comb begin
    state_d      = state_q;
    skew_d       = skew_q;
    verdict_d    = verdict_q;
    scan_idx_d   = scan_idx_q;
    slot_d       = slot_q;
    victim_d     = victim_q;
    vrank_d      = vrank_q;
    found_d      = found_q;
    mark_live_d  = mark_live_q;
    rank_clock_d = rank_clock_q;
    rd_en        = 1'b0;
    rd_addr      = '0;
    wr_en        = 1'b0;
    wr_data      = rd_q;
    out_load     = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_i.valid) state_d = ST_SKEW;
      end

      ST_SKEW: begin
        skew_d     = time_mode_q ? diff[63:32] : 32'd0;
        scan_idx_d = '0;
        rd_en      = 1'b1;
        if (time_mode_q && outside_win(diff[63:32], window_q)) begin
          verdict_d = VERDICT_STALE;
          state_d   = ST_DONE;
        end else if (!adv_q.hmac_good) begin
          verdict_d = VERDICT_BAD_HMAC;
          state_d   = ST_DONE;
        end else begin
          state_d = ST_SCAN;
        end
      end

      ST_SCAN: begin
        rd_en = 1'b1;
        if (cur_less) begin
          victim_d = scan_idx_q;
          vrank_d  = cur_rank;
        end
        if (cur_match) begin
          found_d = 1'b1;
          slot_d  = scan_idx_q;
          rd_addr = scan_idx_q;
          state_d = ST_AGE;
        end else if (scan_idx_q == LAST_IDX) begin
          found_d = 1'b0;
          slot_d  = cur_less ? scan_idx_q : victim_q;
          rd_addr = slot_d;
          state_d = ST_AGE;
        end else begin
          scan_idx_d = scan_idx_q + IDX_W'(1);
          rd_addr    = scan_idx_d;
        end
      end

      ST_AGE: begin
        mark_live_d = found_q && mark_valid_q[slot_q] &&
                      !(time_mode_q && outside_win(diff[63:32], window_q));
        state_d     = ST_SERIAL;
      end

      ST_SERIAL: begin
        wr_en             = 1'b1;
        wr_data.rank      = rank_next;
        wr_data.is_v6     = adv_q.addr_is_v6;
        wr_data.addr_high = adv_q.addr_high;
        wr_data.addr_low  = adv_q.addr_low;
        wr_data.mark_seq  = replay ? rd_q.mark_seq : adv_q.sequence_req;
        rank_clock_d      = rank_next;
        verdict_d         = replay ? VERDICT_REPLAY : VERDICT_OK;
        state_d           = ST_DONE;
      end

      ST_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      rank_clock_q <= '0;
      used_q       <= '0;
      mark_valid_q <= '0;
    end else begin
      state_q      <= state_d;
      rank_clock_q <= rank_clock_d;
      // A written slot is occupied and its mark is valid either way
      if (wr_en) begin
        used_q[slot_q]       <= 1'b1;
        mark_valid_q[slot_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    skew_q      <= skew_d;
    verdict_q   <= verdict_d;
    scan_idx_q  <= scan_idx_d;
    slot_q      <= slot_d;
    victim_q    <= victim_d;
    vrank_q     <= vrank_d;
    found_q     <= found_d;
    mark_live_q <= mark_live_d;
  end

  // Checks
  a_mark_in_used: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mark_valid_q & ~used_q) == '0)
    else $error("mark valid on an empty slot");

  a_rank_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SERIAL |=> rank_clock_q != 32'd0)
    else $error("rank clock zero after bump");

  a_slot_marked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SERIAL |=> mark_valid_q[$past(slot_q)] && used_q[$past(slot_q)])
    else $error("updated slot not marked");

  a_busy_no_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("advert taken while busy");

endmodule

`default_nettype wire
